FILE: design/rrst_pkg.sv
// Shared constants, types and control structs of the round-robin schedule timing block.
package rrst_pkg;

    // Default process capacity
    localparam int MAX_PROCS_DEF = 16;

    // Field widths
    localparam int ARR_W     = 16;
    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 16;
    localparam int TIME_W    = 21;
    localparam int PIDX_W    = 4;

    // Saturation limit of reported times
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-3:0] REG_QUANTUM = '0;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

    // One entry of the process store
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [TIME_W-1:0]  completion;
    } proc_t;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_item;
        logic load_start;
        logic ins_shift;
        logic ins_put;
        logic run_init;
        logic turn_rd;
        logic turn_pick;
        logic turn_exec;
        logic turn_wb;
        logic out_rd;
        logic out_pick;
        logic out_tat;
        logic out_wt;
        logic out_next;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic ins_greater;
        logic pos_one;
        logic item_last;
        logic rem_done;
        logic count_zero;
        logic out_last;
    } stat_t;

endpackage

FILE: design/rrst_if.sv
// Item channel interfaces: process load items in, timing result items out.
interface rrst_in_if;
    logic                          valid;
    logic                          ready;
    logic [rrst_pkg::ARR_W-1:0]    arrival;
    logic [rrst_pkg::BURST_W-1:0]  burst;
    logic                          last_process;

    modport source (output valid, output arrival, output burst,
                    output last_process, input ready);
    modport sink   (input valid, input arrival, input burst,
                    input last_process, output ready);
endinterface

interface rrst_out_if;
    logic                          valid;
    logic                          ready;
    logic [rrst_pkg::PIDX_W-1:0]   process_index;
    logic [rrst_pkg::TIME_W-1:0]   completion;
    logic [rrst_pkg::TIME_W-1:0]   turnaround;
    logic [rrst_pkg::TIME_W-1:0]   waiting;
    logic                          last_result;

    modport source (output valid, output process_index, output completion,
                    output turnaround, output waiting, output last_result,
                    input ready);
    modport sink   (input valid, input process_index, input completion,
                    input turnaround, input waiting, input last_result,
                    output ready);
endinterface

FILE: design/rrst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: design/rrst_cfg.sv
// APB register bank holding the time quantum.
module rrst_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rrst_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rrst_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rrst_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [rrst_pkg::QUANTUM_W-1:0]  quantum
);
    localparam int QW = rrst_pkg::QUANTUM_W;
    localparam int DW = rrst_pkg::CFG_DATA_W;
    localparam int AW = rrst_pkg::CFG_ADDR_W;

    logic [QW-1:0] quantum_reg;
    logic          sel_quantum;

    // Word index decode
    assign sel_quantum = (paddr[AW-1:2] == rrst_pkg::REG_QUANTUM);
    assign pready      = 1'b1;

    // Register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrst_pkg::QUANTUM_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_quantum)
        begin
            quantum_reg <= pwdata[QW-1:0];
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (sel_quantum)
        begin
            prdata = DW'(quantum_reg);
        end
    end

    assign quantum = quantum_reg;
endmodule

FILE: design/rrst_ctrl.sv
// Sequencer for load, insertion, round-robin turns and result output.
module rrst_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rrst_pkg::stat_t stat,
    output rrst_pkg::cmd_t  cmd
);
    typedef enum logic [13:0] {
        S_IDLE     = 14'd1,
        S_LOAD     = 14'd2,
        S_INS      = 14'd4,
        S_PUT      = 14'd8,
        S_RUN_INIT = 14'd16,
        S_TURN_RD  = 14'd32,
        S_TURN_P   = 14'd64,
        S_TURN_EX  = 14'd128,
        S_TURN_WB  = 14'd256,
        S_OUT_RD   = 14'd512,
        S_OUT_P    = 14'd1024,
        S_OUT_TAT  = 14'd2048,
        S_OUT_WT   = 14'd4096,
        S_OUT_HOLD = 14'd8192
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT_HOLD);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (stat.full)
                begin
                    // store full: item dropped, a last mark still starts the run
                    state_next = stat.item_last ? S_RUN_INIT : S_IDLE;
                end
                else
                begin
                    cmd.load_start = 1'b1;
                    state_next     = stat.cnt_zero ? S_PUT : S_INS;
                end
            end
            S_INS:
            begin
                if (stat.ins_greater)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = stat.pos_one ? S_PUT : S_INS;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.ins_put = 1'b1;
                state_next  = stat.item_last ? S_RUN_INIT : S_IDLE;
            end
            S_RUN_INIT:
            begin
                cmd.run_init = 1'b1;
                state_next   = S_TURN_RD;
            end
            S_TURN_RD:
            begin
                cmd.turn_rd = 1'b1;
                state_next  = S_TURN_P;
            end
            S_TURN_P:
            begin
                cmd.turn_pick = 1'b1;
                state_next    = S_TURN_EX;
            end
            S_TURN_EX:
            begin
                cmd.turn_exec = 1'b1;
                state_next    = S_TURN_WB;
            end
            S_TURN_WB:
            begin
                cmd.turn_wb = 1'b1;
                state_next  = (stat.rem_done && stat.count_zero) ? S_OUT_RD : S_TURN_RD;
            end
            S_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OUT_P;
            end
            S_OUT_P:
            begin
                cmd.out_pick = 1'b1;
                state_next   = S_OUT_TAT;
            end
            S_OUT_TAT:
            begin
                cmd.out_tat = 1'b1;
                state_next  = S_OUT_WT;
            end
            S_OUT_WT:
            begin
                cmd.out_wt = 1'b1;
                state_next = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (out_ready)
                begin
                    cmd.out_next = 1'b1;
                    state_next   = stat.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

FILE: design/rrst_dp.sv
// Datapath: process, order and ring memories, counters, time arithmetic, result registers.
module rrst_dp #(
    parameter int MAX_PROCS = rrst_pkg::MAX_PROCS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rrst_pkg::cmd_t                 cmd,
    output rrst_pkg::stat_t                stat,
    input  logic [rrst_pkg::ARR_W-1:0]     in_arrival,
    input  logic [rrst_pkg::BURST_W-1:0]   in_burst,
    input  logic                           in_last,
    input  logic [rrst_pkg::QUANTUM_W-1:0] quantum,
    output logic [rrst_pkg::PIDX_W-1:0]    out_pidx,
    output logic [rrst_pkg::TIME_W-1:0]    out_comp,
    output logic [rrst_pkg::TIME_W-1:0]    out_tat,
    output logic [rrst_pkg::TIME_W-1:0]    out_wt,
    output logic                           out_last
);
    localparam int ARR_W   = rrst_pkg::ARR_W;
    localparam int BURST_W = rrst_pkg::BURST_W;
    localparam int TIME_W  = rrst_pkg::TIME_W;
    localparam int PIDX_W  = rrst_pkg::PIDX_W;
    localparam int IDX_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W   = $clog2(MAX_PROCS + 1);
    // time can reach (MAX_PROCS + 1) * 65535; keep at least one bit above the report width
    localparam int SIM_RAW = BURST_W + $clog2(MAX_PROCS + 1);
    localparam int SIM_W   = (SIM_RAW > TIME_W) ? SIM_RAW : TIME_W + 1;
    localparam int ORD_W   = ARR_W + IDX_W;
    localparam int PROC_W  = $bits(rrst_pkg::proc_t);

    // Latched load item
    logic [ARR_W-1:0]   item_arr_reg;
    logic [BURST_W-1:0] item_bst_reg;
    logic               item_last_reg;

    // Counters
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] i_reg;

    // Turn state
    logic [SIM_W-1:0]   sim_reg;
    logic [BURST_W-1:0] run_reg;
    logic [IDX_W-1:0]   p_reg;
    rrst_pkg::proc_t    proc_reg;

    // Result registers
    logic [PIDX_W-1:0] pidx_reg;
    logic [TIME_W-1:0] comp_reg;
    logic [TIME_W-1:0] tat_reg;
    logic [TIME_W-1:0] wt_reg;
    logic              last_reg;

    // Memory ports
    logic                  proc_we;
    logic [IDX_W-1:0]      proc_waddr;
    rrst_pkg::proc_t       proc_wdata;
    logic                  proc_re;
    logic [IDX_W-1:0]      proc_raddr;
    logic [PROC_W-1:0]     proc_rdata_raw;
    rrst_pkg::proc_t       proc_rdata;

    logic                  ord_we;
    logic [IDX_W-1:0]      ord_waddr;
    logic [ORD_W-1:0]      ord_wdata;
    logic                  ord_re;
    logic [IDX_W-1:0]      ord_raddr;
    logic [ORD_W-1:0]      ord_rdata;

    logic                  ring_we;
    logic [IDX_W-1:0]      ring_waddr;
    logic [IDX_W-1:0]      ring_wdata;
    logic [IDX_W-1:0]      ring_rdata;

    // Arithmetic
    localparam int QUANTUM_W_L = rrst_pkg::QUANTUM_W;
    logic [QUANTUM_W_L-1:0] q_eff;
    logic [IDX_W-1:0]   cnt_idx;
    logic [IDX_W-1:0]   head_inc;
    logic [CNT_W:0]     tail_sum;
    logic [IDX_W-1:0]   tail_idx;
    logic [BURST_W-1:0] rem_new;
    logic [SIM_W-1:0]   sim_new;
    logic [TIME_W-1:0]  comp_sat;
    logic [SIM_W-1:0]   arr_ext;
    logic [BURST_W-1:0] run_min;
    logic [TIME_W-1:0]  tat_new;
    logic [TIME_W-1:0]  bst_ext;
    logic               rem_done;

    assign cnt_idx  = cnt_reg[IDX_W-1:0];
    assign q_eff    = (quantum == '0) ? QUANTUM_W_L'(1) : quantum;
    assign head_inc = (head_reg == IDX_W'(MAX_PROCS - 1)) ? '0 : head_reg + IDX_W'(1);

    // Ring tail position, wrapped once
    always_comb
    begin
        tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
        if (tail_sum >= (CNT_W + 1)'(MAX_PROCS))
        begin
            tail_sum = tail_sum - (CNT_W + 1)'(MAX_PROCS);
        end
        tail_idx = tail_sum[IDX_W-1:0];
    end

    // Turn arithmetic
    assign arr_ext  = SIM_W'(proc_rdata.arrival);
    assign run_min  = (proc_rdata.remaining < q_eff) ? proc_rdata.remaining : q_eff;
    assign rem_new  = proc_reg.remaining - run_reg;
    assign rem_done = (proc_reg.remaining == run_reg);
    assign sim_new  = sim_reg + SIM_W'(run_reg);
    assign comp_sat = (sim_new > SIM_W'(rrst_pkg::TIME_MAX)) ? rrst_pkg::TIME_MAX
                                                            : sim_new[TIME_W-1:0];

    // Result arithmetic
    assign tat_new = proc_rdata.completion - TIME_W'(proc_rdata.arrival);
    assign bst_ext = TIME_W'(proc_reg.burst);

    // Process store ports
    always_comb
    begin
        proc_we    = cmd.load_start || cmd.turn_wb;
        proc_waddr = cmd.load_start ? cnt_idx : p_reg;
        if (cmd.load_start)
        begin
            proc_wdata.arrival    = item_arr_reg;
            proc_wdata.burst      = item_bst_reg;
            proc_wdata.remaining  = item_bst_reg;
            proc_wdata.completion = '0;
        end
        else
        begin
            proc_wdata.arrival    = proc_reg.arrival;
            proc_wdata.burst      = proc_reg.burst;
            proc_wdata.remaining  = rem_new;
            proc_wdata.completion = rem_done ? comp_sat : proc_reg.completion;
        end
        proc_re    = cmd.turn_pick || cmd.out_pick;
        proc_raddr = cmd.turn_pick ? ring_rdata : ord_rdata[IDX_W-1:0];
    end

    assign proc_rdata = rrst_pkg::proc_t'(proc_rdata_raw);

    // Arrival-order store ports: entries are {arrival, load index}
    always_comb
    begin
        ord_we    = cmd.ins_shift || cmd.ins_put;
        ord_waddr = pos_reg;
        ord_wdata = cmd.ins_shift ? ord_rdata : {item_arr_reg, cnt_idx};
        ord_re    = cmd.load_start || cmd.ins_shift || cmd.out_rd;
        if (cmd.load_start)
        begin
            ord_raddr = cnt_idx - IDX_W'(1);
        end
        else if (cmd.ins_shift)
        begin
            ord_raddr = pos_reg - IDX_W'(2);
        end
        else
        begin
            ord_raddr = i_reg;
        end
    end

    // Ready ring ports: insertion mirrors the order store, turns requeue at the tail
    always_comb
    begin
        ring_we    = cmd.ins_shift || cmd.ins_put || (cmd.turn_wb && !rem_done);
        ring_waddr = cmd.turn_wb ? tail_idx : pos_reg;
        if (cmd.turn_wb)
        begin
            ring_wdata = p_reg;
        end
        else if (cmd.ins_shift)
        begin
            ring_wdata = ord_rdata[IDX_W-1:0];
        end
        else
        begin
            ring_wdata = cnt_idx;
        end
    end

    rrst_ram #(.WIDTH(PROC_W), .DEPTH(MAX_PROCS)) u_proc_ram (
        .clk   (clk),
        .we    (proc_we),
        .waddr (proc_waddr),
        .wdata (proc_wdata),
        .re    (proc_re),
        .raddr (proc_raddr),
        .rdata (proc_rdata_raw)
    );

    rrst_ram #(.WIDTH(ORD_W), .DEPTH(MAX_PROCS)) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    rrst_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (cmd.turn_rd),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pos_reg   <= '0;
            head_reg  <= '0;
            count_reg <= '0;
            i_reg     <= '0;
            sim_reg   <= '0;
        end
        else
        begin
            if (cmd.ins_put)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.out_next && stat.out_last)
            begin
                cnt_reg <= '0;
            end

            if (cmd.load_start)
            begin
                pos_reg <= cnt_idx;
            end
            else if (cmd.ins_shift)
            begin
                pos_reg <= pos_reg - IDX_W'(1);
            end

            if (cmd.run_init)
            begin
                head_reg <= '0;
            end
            else if (cmd.turn_pick)
            begin
                head_reg <= head_inc;
            end

            if (cmd.run_init)
            begin
                count_reg <= cnt_reg;
            end
            else if (cmd.turn_pick)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.turn_wb && !rem_done)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.run_init)
            begin
                i_reg <= '0;
            end
            else if (cmd.out_next)
            begin
                i_reg <= i_reg + IDX_W'(1);
            end

            // idle time jumps forward to the arrival, then the slice runs
            if (cmd.run_init)
            begin
                sim_reg <= '0;
            end
            else if (cmd.turn_exec)
            begin
                if (sim_reg < arr_ext)
                begin
                    sim_reg <= arr_ext;
                end
            end
            else if (cmd.turn_wb)
            begin
                sim_reg <= sim_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_arr_reg  <= in_arrival;
            item_bst_reg  <= in_burst;
            item_last_reg <= in_last;
        end
        if (cmd.turn_pick)
        begin
            p_reg <= ring_rdata;
        end
        else if (cmd.out_pick)
        begin
            p_reg <= ord_rdata[IDX_W-1:0];
        end
        if (cmd.turn_exec || cmd.out_tat)
        begin
            proc_reg <= proc_rdata;
        end
        if (cmd.turn_exec)
        begin
            run_reg <= run_min;
        end
        if (cmd.out_tat)
        begin
            pidx_reg <= PIDX_W'(p_reg);
            comp_reg <= proc_rdata.completion;
            tat_reg  <= tat_new;
            last_reg <= stat.out_last;
        end
        if (cmd.out_wt)
        begin
            wt_reg <= (tat_reg >= bst_ext) ? tat_reg - bst_ext : '0;
        end
    end

    // Status
    always_comb
    begin
        stat.full        = (cnt_reg == CNT_W'(MAX_PROCS));
        stat.cnt_zero    = (cnt_reg == '0);
        stat.ins_greater = (ord_rdata[ORD_W-1:IDX_W] > item_arr_reg);
        stat.pos_one     = (pos_reg == IDX_W'(1));
        stat.item_last   = item_last_reg;
        stat.rem_done    = rem_done;
        stat.count_zero  = (count_reg == '0);
        stat.out_last    = ((CNT_W'(i_reg) + CNT_W'(1)) == cnt_reg);
    end

    assign out_pidx = pidx_reg;
    assign out_comp = comp_reg;
    assign out_tat  = tat_reg;
    assign out_wt   = wt_reg;
    assign out_last = last_reg;
endmodule

FILE: design/round_robin_schedule_timing.sv
// Top level of the round-robin schedule timing block.
//
// Usage: processes arrive on in_ch, one item each (arrival, burst,
// last_process). A load item is latched and stored; the stable insertion then
// moves up each stored process with a later arrival, with a final compare
// unless the item lands at the front of the store; items beyond MAX_PROCS are
// dropped. The item marked last_process starts the run: in_ch.ready stays
// low until every result has been taken. The run starts with a set-up step,
// then each round-robin turn does a ring read, a process read, a slice set-up
// and a write-back. Then one result per process leaves on out_ch in arrival
// order; each result is read out only after the previous one was taken, and
// is held in its output register while the receiver stalls. The final result
// carries last_result and the block returns to loading.
// The quantum register sits at APB address 0; pready is always high; write it
// only while no run is in progress. Reset empties the block and sets the
// quantum to 4; the stores need no clearing.
module round_robin_schedule_timing #(
    parameter int MAX_PROCS = rrst_pkg::MAX_PROCS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rrst_in_if.sink                         in_ch,
    rrst_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rrst_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rrst_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rrst_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    logic [rrst_pkg::QUANTUM_W-1:0] quantum;
    rrst_pkg::cmd_t                 cmd;
    rrst_pkg::stat_t                stat;

    rrst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .quantum (quantum)
    );

    rrst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrst_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_arrival (in_ch.arrival),
        .in_burst   (in_ch.burst),
        .in_last    (in_ch.last_process),
        .quantum    (quantum),
        .out_pidx   (out_ch.process_index),
        .out_comp   (out_ch.completion),
        .out_tat    (out_ch.turnaround),
        .out_wt     (out_ch.waiting),
        .out_last   (out_ch.last_result)
    );
endmodule

FILE: design/rrst_chk.sv
// Port-level checker for the round-robin schedule timing block, with its bind.
module rrst_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rrst_pkg::PIDX_W-1:0]   out_pidx,
    input logic [rrst_pkg::TIME_W-1:0]   out_comp,
    input logic [rrst_pkg::TIME_W-1:0]   out_tat,
    input logic [rrst_pkg::TIME_W-1:0]   out_wt,
    input logic                          out_last,
    input logic                          pready
);
    // Loading and result output never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result item is offered");

    // A load item that is not last produces no result right after
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_last) |=> !out_valid)
        else $error("result item offered right after a plain load item");

    // After the final result the block is ready to load again
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> in_ready)
        else $error("not ready to load after the final result item");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_pidx) &&
            $stable(out_comp) && $stable(out_tat) && $stable(out_wt) &&
            $stable(out_last)))
        else $error("stalled result item changed");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind round_robin_schedule_timing rrst_chk u_rrst_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last_process),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pidx  (out_ch.process_index),
    .out_comp  (out_ch.completion),
    .out_tat   (out_ch.turnaround),
    .out_wt    (out_ch.waiting),
    .out_last  (out_ch.last_result),
    .pready    (pready)
);

FILE: test/round_robin_schedule_timing_tb.sv
// Testbench for the round-robin schedule timing block: APB quantum setup, process loads, result checks.
`timescale 1ns / 1ps

module round_robin_schedule_timing_tb;
    localparam int MAX_PROCS     = rrst_pkg::MAX_PROCS_DEF;
    localparam int ARR_W         = rrst_pkg::ARR_W;
    localparam int BURST_W       = rrst_pkg::BURST_W;
    localparam int QUANTUM_W     = rrst_pkg::QUANTUM_W;
    localparam int TIME_W        = rrst_pkg::TIME_W;
    localparam int PIDX_W        = rrst_pkg::PIDX_W;
    localparam int CFG_ADDR_W    = rrst_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W    = rrst_pkg::CFG_DATA_W;
    localparam logic [TIME_W-1:0]    TIME_MAX      = rrst_pkg::TIME_MAX;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = rrst_pkg::QUANTUM_RESET;
    localparam int MAX_IDLE      = 8;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 220;
    localparam int WATCHDOG_NS   = 5_000_000;
    localparam logic [CFG_ADDR_W-1:0] QUANTUM_ADDR = {rrst_pkg::REG_QUANTUM, 2'b00};

    // One expected timing result
    typedef struct packed {
        logic [PIDX_W-1:0] process_index;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              last_result;
    } timing_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rrst_in_if  in_ch ();
    rrst_out_if out_ch ();

    round_robin_schedule_timing i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: quantum and the processes loaded for the next run
    logic [QUANTUM_W-1:0] quantum_q = QUANTUM_RESET;
    logic [ARR_W-1:0]     held_arrival [MAX_PROCS];
    logic [BURST_W-1:0]   held_burst [MAX_PROCS];
    int unsigned          arrival_rank [MAX_PROCS];
    int unsigned          held_count = 0;

    timing_result_t       expected_results [$];

    int unsigned error_count        = 0;
    int unsigned processes_sent     = 0;
    int unsigned runs_started       = 0;
    int unsigned results_checked    = 0;
    int unsigned quantum_writes     = 0;
    int unsigned result_hold_cycles = 0;
    bit          in_idle            = 1'b1;
    bit          out_idle           = 1'b1;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("round_robin_schedule_timing_tb NOT OK");
        $finish;
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Stable insertion by arrival; processes past the store size are dropped
    function automatic void hold_process(input logic [ARR_W-1:0] arr,
                                         input logic [BURST_W-1:0] bst);
        int unsigned pos;
        if (held_count >= MAX_PROCS)
            return;
        held_arrival[held_count] = arr;
        held_burst[held_count]   = bst;
        pos = held_count;
        while (pos > 0 && held_arrival[arrival_rank[pos-1]] > arr)
        begin
            arrival_rank[pos] = arrival_rank[pos-1];
            pos--;
        end
        arrival_rank[pos] = held_count;
        held_count++;
    endfunction

    // Round-robin run over the held processes; queues one result per process
    function automatic void run_round_robin();
        int unsigned    ring [$];
        int unsigned    left_over [MAX_PROCS];
        int unsigned    done_at [MAX_PROCS];
        int unsigned    slice;
        int unsigned    now;
        int unsigned    p;
        int unsigned    ran;
        int unsigned    tat;
        int unsigned    wt;
        timing_result_t r;
        slice = (quantum_q == 0) ? 1 : quantum_q;
        now = 0;
        for (int i = 0; i < held_count; i++)
        begin
            ring.insert(ring.size(), arrival_rank[i]);
            left_over[arrival_rank[i]] = held_burst[arrival_rank[i]];
        end
        while (ring.size() > 0)
        begin
            p = ring.pop_front();
            if (now < held_arrival[p])
                now = held_arrival[p];
            ran = (left_over[p] < slice) ? left_over[p] : slice;
            left_over[p] -= ran;
            now += ran;
            if (left_over[p] == 0)
                done_at[p] = (now > TIME_MAX) ? TIME_MAX : now;
            else
                ring.insert(ring.size(), p);
        end
        // Results leave in arrival order
        for (int i = 0; i < held_count; i++)
        begin
            p   = arrival_rank[i];
            tat = done_at[p] - held_arrival[p];
            wt  = (tat >= held_burst[p]) ? tat - held_burst[p] : 0;
            r.process_index = p[PIDX_W-1:0];
            r.completion    = done_at[p][TIME_W-1:0];
            r.turnaround    = tat[TIME_W-1:0];
            r.waiting       = wt[TIME_W-1:0];
            r.last_result   = (i + 1 == held_count);
            expected_results.insert(expected_results.size(), r);
        end
        held_count = 0;
    endfunction

    // Offer one process item and wait for the block to take it
    task automatic send_process(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bst,
                                input logic last);
        int unsigned gap;
        gap = in_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.arrival      <= arr;
        in_ch.burst        <= bst;
        in_ch.last_process <= last;
        do @(posedge clk); while (!in_ch.ready);
        processes_sent++;
        hold_process(arr, bst);
        if (last)
        begin
            runs_started++;
            run_round_robin();
        end
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB read of the quantum register
    task automatic readback_quantum(input logic [QUANTUM_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= QUANTUM_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("quantum", want, prdata[QUANTUM_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // APB write of the quantum register, then read it back; block must be idle
    task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QUANTUM_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        quantum_q = value;
        quantum_writes++;
        @(posedge clk);
        readback_quantum(value);
    endtask

    // Reset quantum of 4, out-of-order arrival, zero burst
    task automatic test_default_quantum();
        readback_quantum(QUANTUM_RESET);
        send_process(16'd0, 16'd5, 1'b0);
        send_process(16'd2, 16'd3, 1'b0);
        send_process(16'd1, 16'd0, 1'b1);
        drain_results();
    endtask

    // Smallest and largest quantum, field extremes, equal arrivals
    task automatic test_quantum_extremes();
        write_quantum(16'd1);
        send_process(16'd0, 16'd3, 1'b0);
        send_process(16'd0, 16'd2, 1'b1);
        drain_results();
        write_quantum(16'hFFFF);
        send_process(16'hFFFF, 16'hFFFF, 1'b0);
        send_process(16'd0, 16'hFFFF, 1'b1);
        drain_results();
    endtask

    // A zero quantum behaves as one
    task automatic test_zero_quantum();
        write_quantum(16'd0);
        send_process(16'd7, 16'd2, 1'b0);
        send_process(16'd7, 16'd0, 1'b1);
        drain_results();
    endtask

    // Full store with worst-case insertion, then a dropped item and a dropped last item
    task automatic test_store_full();
        write_quantum(16'd8);
        for (int i = 0; i < MAX_PROCS; i++)
            send_process(16'(1000 - 10 * i), 16'(i + 1), 1'b0);
        send_process(16'd0, 16'd1, 1'b0);
        send_process(16'd0, 16'd1, 1'b1);
        drain_results();
    endtask

    // Receiver holds off while the next run is already being offered
    task automatic test_result_backpressure();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        result_hold_cycles = LONG_HOLD;
        for (int i = 0; i < MAX_PROCS; i++)
            send_process(16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)),
                         i == MAX_PROCS - 1);
        for (int i = 0; i < 4; i++)
            send_process(16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)), i == 3);
        drain_results();
    endtask

    // Random runs with clustered arrivals and bursts scaled to the quantum
    task automatic test_random_runs();
        int unsigned          sent;
        int unsigned          runs;
        int unsigned          run_len;
        int unsigned          q_eff;
        int unsigned          burst_cap;
        int unsigned          spread;
        int unsigned          base;
        logic [ARR_W-1:0]     arr;
        logic [ARR_W-1:0]     prev_arr;
        logic [BURST_W-1:0]   bst;
        sent     = 0;
        runs     = 0;
        prev_arr = '0;
        while (sent < RANDOM_ITEMS)
        begin
            // New quantum every few runs, only once the block is idle
            if (runs % 4 == 0)
            begin
                drain_results();
                case ($urandom_range(0, 5))
                    0: write_quantum(16'd1);
                    1: write_quantum(16'($urandom_range(2, 16)));
                    2: write_quantum(16'($urandom_range(17, 65534)));
                    3: write_quantum(16'hFFFF);
                    4: write_quantum(16'd0);
                    default: write_quantum(16'($urandom_range(256, 4096)));
                endcase
            end
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            q_eff     = (quantum_q == 0) ? 1 : quantum_q;
            burst_cap = (q_eff * 12 > 65535) ? 65535 : q_eff * 12;
            spread    = ($urandom_range(0, 3) == 0 || burst_cap * 4 > 65535) ?
                        65535 : burst_cap * 4;
            base      = $urandom_range(0, 65535 - spread);
            run_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4)
                                                    : $urandom_range(1, MAX_PROCS);
            for (int i = 0; i < run_len; i++)
            begin
                if (i > 0 && $urandom_range(0, 5) == 0)
                    arr = prev_arr;
                else
                    arr = 16'(base + $urandom_range(0, spread));
                case ($urandom_range(0, 15))
                    0, 1: bst = '0;
                    2: bst = 16'(burst_cap);
                    default: bst = 16'($urandom_range(1, burst_cap));
                endcase
                send_process(arr, bst, i == run_len - 1);
                prev_arr = arr;
            end
            sent += run_len;
            runs++;
        end
    endtask

    // Result receiver: random stall per item, plus one long hold on request
    initial
    begin : result_receiver
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (result_hold_cycles > 0)
            begin
                stall = result_hold_cycles;
                result_hold_cycles = 0;
            end
            else
                stall = out_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        timing_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item: process_index %0d", out_ch.process_index);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("process_index", want.process_index, out_ch.process_index);
                check_field("completion", want.completion, out_ch.completion);
                check_field("turnaround", want.turnaround, out_ch.turnaround);
                check_field("waiting", want.waiting, out_ch.waiting);
                check_field("last_result", want.last_result, out_ch.last_result);
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.arrival      <= '0;
        in_ch.burst        <= '0;
        in_ch.last_process <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_quantum();
        test_quantum_extremes();
        test_zero_quantum();
        test_store_full();
        test_result_backpressure();
        test_random_runs();
        drain_results();

        $display("Loaded %0d processes over %0d schedule runs; %0d timing results compared.",
                 processes_sent, runs_started, results_checked);
        $display("%0d quantum writes incl. 0, 1 and 65535; store overflow and a %0d-cycle hold.",
                 quantum_writes, LONG_HOLD);
        if (error_count == 0)
            $display("round_robin_schedule_timing_tb OK");
        else
            $display("round_robin_schedule_timing_tb NOT OK");
        $finish;
    end

endmodule
